[rtl/core/cyclotomic_z9_ring_alu_unit_defines.svh]
// Assertion macros for the ring ALU unit.
`ifndef CYCLOTOMIC_Z9_RING_ALU_UNIT_DEFINES_SVH
`define CYCLOTOMIC_Z9_RING_ALU_UNIT_DEFINES_SVH
// Checks that an implication holds on every rising clock edge outside reset.
`define CZ_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// Checks that a condition holds in the cycle after a trigger.
`define CZ_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

[rtl/core/cz9_pkg.sv]
// ----------------------------------------------------------------------------
// cz9_pkg
// Types, opcodes and sequencer states of the ninth-root ring ALU.
// ----------------------------------------------------------------------------
package cz9_pkg;

  localparam int CoeffWidth = 32;
  localparam int NumCoeff = 6;

  typedef logic signed [CoeffWidth-1:0] coeff_t;
  typedef coeff_t [NumCoeff-1:0] vec_t;

  typedef enum logic [3:0] {
    OP_LOAD = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_SCALE = 4'd4,
    OP_DIV = 4'd5, OP_GALOIS = 4'd6, OP_NORM = 4'd7, OP_TRACE = 4'd8
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SCALE, ST_DIV_START, ST_DIV_WAIT, ST_NCONJ, ST_NMUL,
    ST_WEIGHT, ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]   opcode;
    coeff_t       operand_c0;
    coeff_t       operand_c1;
    coeff_t       operand_c2;
    coeff_t       operand_c3;
    coeff_t       operand_c4;
    coeff_t       operand_c5;
    coeff_t       scalar_value;
    logic [3:0]   galois_power;
  } in_item_t;

  typedef struct packed {
    coeff_t result_c0;
    coeff_t result_c1;
    coeff_t result_c2;
    coeff_t result_c3;
    coeff_t result_c4;
    coeff_t result_c5;
    coeff_t norm_or_trace;
    coeff_t quad_form;
    coeff_t abs_weight;
    coeff_t signed_sum;
    logic   divide_by_zero;
  } out_item_t;

  // Fold a cyclic nine-term vector using z^(r+6) = -z^r - z^(r+3).
  function automatic vec_t fold9(input coeff_t t [9]);
    vec_t d;
    for (int r = 0; r < 3; r++) begin
      d[r] = t[r] - t[r+6];
      d[r+3] = t[r+3] - t[r+6];
    end
    return d;
  endfunction

  // Galois map z -> z^k for k below nine, then fold.
  function automatic vec_t galois_map(input vec_t a, input logic [3:0] k);
    coeff_t t [9];
    logic [4:0] e;
    for (int i = 0; i < 9; i++) t[i] = '0;
    e = '0;
    for (int i = 0; i < NumCoeff; i++) begin
      t[e[3:0]] = t[e[3:0]] + a[i];
      // Step the exponent by k, modulo nine.
      e = e + 5'(k);
      if (e >= 5'd9) e = e - 5'd9;
    end
    return fold9(t);
  endfunction

  // Conjugate exponents of the norm in order.
  function automatic logic [3:0] conj_power(input logic [2:0] n);
    logic [3:0] r;
    unique case (n)
      3'd0: r = 4'd1;
      3'd1: r = 4'd2;
      3'd2: r = 4'd4;
      3'd3: r = 4'd5;
      3'd4: r = 4'd7;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mod9(input logic [3:0] k);
    return (k >= 4'd9) ? k - 4'd9 : k;
  endfunction

endpackage

[rtl/core/cz9_divider.sv]
// ----------------------------------------------------------------------------
// cz9_divider
// Radix-2 restoring divider for signed values, truncating toward zero.
// ----------------------------------------------------------------------------
module cz9_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cz9_pkg::coeff_t dividend,
  input  cz9_pkg::coeff_t divisor,
  output logic            busy,
  output logic            done,
  output cz9_pkg::coeff_t quotient
);
  import cz9_pkg::*;

  localparam int CntW = $clog2(CoeffWidth + 1);

  logic [CoeffWidth-1:0] rem_q;
  logic [CoeffWidth-1:0] quo;
  logic [CoeffWidth-1:0] mag_d;
  logic [CntW-1:0]       count;
  logic                  neg;
  logic [CoeffWidth:0]   trial;

  // One quotient bit a cycle.
  assign trial = {rem_q, quo[CoeffWidth-1]} - {1'b0, mag_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CntW'(CoeffWidth);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo <= dividend[CoeffWidth-1] ? -dividend : dividend;
      mag_d <= divisor[CoeffWidth-1] ? -divisor : divisor;
      neg <= dividend[CoeffWidth-1] ^ divisor[CoeffWidth-1];
    end else if (busy) begin
      if (!trial[CoeffWidth]) begin
        rem_q <= trial[CoeffWidth-1:0];
        quo <= {quo[CoeffWidth-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CoeffWidth-2:0], quo[CoeffWidth-1]};
        quo <= {quo[CoeffWidth-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -coeff_t'(quo) : coeff_t'(quo);

endmodule

[rtl/core/cyclotomic_z9_ring_alu_unit.sv]
// Ring ALU for integers of the ninth roots of unity. One item at a time:
// load, add, sub, galois, trace, unused opcodes and a zero divide go
// straight to the weight step; scale uses the one shared 32x32 multiplier
// per coefficient, multiply forms 36 products on it, divide makes six passes
// through the bit-serial divider, and norm chains six conjugates through
// ring products, each conjugate formed in its own state before its product.
// Every operation ends by computing the weights, again on the shared
// multiplier. in_ready is high only while idle.
// ----------------------------------------------------------------------------
// cyclotomic_z9_ring_alu_unit
// Sequenced accumulator ALU over Z[z]/(z^6+z^3+1) with one shared multiplier.
// ----------------------------------------------------------------------------
`include "cyclotomic_z9_ring_alu_unit_defines.svh"
module cyclotomic_z9_ring_alu_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cz9_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cz9_pkg::out_item_t  out_data
);
  import cz9_pkg::*;

  state_t state, state_next;
  in_item_t item;
  vec_t acc, opnd, work, conj;
  coeff_t term [9];
  coeff_t term_upd [9];
  logic [2:0] ia, ib, nidx;
  logic [3:0] widx;
  coeff_t nt, quad, absw, ssum;
  logic dz;
  coeff_t mul_a, mul_b, prod;
  logic [3:0] sum_ij;
  logic [3:0] tix;
  logic div_start;
  logic div_busy;
  logic div_done;
  coeff_t quotient;
  vec_t opv;

  assign opv = {in_data.operand_c5, in_data.operand_c4, in_data.operand_c3,
                in_data.operand_c2, in_data.operand_c1, in_data.operand_c0};

  // Shared multiplier, low half only is kept.
  assign prod = mul_a * mul_b;
  assign sum_ij = 4'(ia) + 4'(ib);
  assign tix = (sum_ij >= 4'd9) ? sum_ij - 4'd9 : sum_ij;

  // Cyclic terms with the current product added in.
  always_comb begin
    for (int i = 0; i < 9; i++) term_upd[i] = term[i] + ((tix == 4'(i)) ? prod : '0);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL: begin
        mul_a = acc[ia];
        mul_b = opnd[ib];
      end
      ST_NMUL: begin
        mul_a = work[ia];
        mul_b = conj[ib];
      end
      ST_SCALE: begin
        mul_a = acc[ia];
        mul_b = item.scalar_value;
      end
      ST_WEIGHT: begin
        if (widx < 4'd6) begin
          mul_a = acc[widx[2:0]];
          mul_b = acc[widx[2:0]];
        end else begin
          mul_a = acc[3'(widx - 4'd6)];
          mul_b = acc[3'(widx - 4'd3)];
        end
      end
      default: ;
    endcase
  end

  cz9_divider u_div (
    .clk, .rst, .start(div_start), .dividend(acc[ia]), .divisor(item.scalar_value),
    .busy(div_busy), .done(div_done), .quotient
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        priority case (in_data.opcode)
          OP_MUL: state_next = ST_MUL;
          OP_SCALE: state_next = ST_SCALE;
          OP_DIV: state_next = (in_data.scalar_value == '0) ? ST_WEIGHT : ST_DIV_START;
          OP_NORM: state_next = ST_NCONJ;
          default: state_next = ST_WEIGHT;
        endcase
      end
      ST_MUL: if (ia == 3'd5 && ib == 3'd5) state_next = ST_WEIGHT;
      ST_SCALE: if (ia == 3'd5) state_next = ST_WEIGHT;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = (ia == 3'd5) ? ST_WEIGHT : ST_DIV_START;
      ST_NCONJ: state_next = ST_NMUL;
      ST_NMUL: if (ia == 3'd5 && ib == 3'd5)
        state_next = (nidx == 3'd5) ? ST_WEIGHT : ST_NCONJ;
      ST_WEIGHT: if (widx == 4'd8) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
    div_start = (state == ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          item <= in_data;
          opnd <= opv;
          ia <= '0;
          ib <= '0;
          nidx <= '0;
          widx <= '0;
          dz <= (in_data.opcode == OP_DIV) && (in_data.scalar_value == '0);
          // The six conjugates of an element sum to 6*c0 - 3*c3.
          nt <= (in_data.opcode == OP_TRACE)
              ? (acc[0] <<< 2) + (acc[0] <<< 1) - (acc[3] <<< 1) - acc[3] : '0;
          quad <= '0;
          absw <= '0;
          ssum <= '0;
          for (int i = 0; i < 9; i++) term[i] <= '0;
          work <= vec_t'(1);
          unique case (in_data.opcode)
            OP_LOAD: acc <= opv;
            OP_ADD: for (int i = 0; i < 6; i++) acc[i] <= acc[i] + opv[i];
            OP_SUB: for (int i = 0; i < 6; i++) acc[i] <= acc[i] - opv[i];
            OP_GALOIS: acc <= galois_map(acc, mod9(in_data.galois_power));
            default: ;
          endcase
        end
        ST_MUL, ST_NMUL: begin
          if (ia == 3'd5 && ib == 3'd5) begin
            // Last product: fold the completed terms and start over.
            ia <= '0;
            ib <= '0;
            for (int i = 0; i < 9; i++) term[i] <= '0;
            if (state == ST_MUL) begin
              acc <= fold9(term_upd);
            end else begin
              work <= fold9(term_upd);
              nidx <= nidx + 3'd1;
              if (nidx == 3'd5) nt <= term_upd[0] - term_upd[6];
            end
          end else begin
            for (int i = 0; i < 9; i++) term[i] <= term_upd[i];
            if (ib == 3'd5) begin
              ib <= '0;
              ia <= ia + 3'd1;
            end else begin
              ib <= ib + 3'd1;
            end
          end
        end
        ST_SCALE: begin
          acc[ia] <= prod;
          ia <= ia + 3'd1;
        end
        ST_DIV_WAIT: if (div_done) begin
          acc[ia] <= quotient;
          ia <= (ia == 3'd5) ? '0 : ia + 3'd1;
        end
        ST_NCONJ: conj <= galois_map(acc, conj_power(nidx));
        ST_WEIGHT: begin
          widx <= widx + 4'd1;
          if (widx < 4'd6) begin
            quad <= quad + prod;
            absw <= absw + (acc[widx[2:0]][CoeffWidth-1] ? -acc[widx[2:0]]
                : acc[widx[2:0]]);
            ssum <= ssum + acc[widx[2:0]];
          end else begin
            quad <= quad - prod;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_data = '{result_c0: acc[0], result_c1: acc[1], result_c2: acc[2],
                      result_c3: acc[3], result_c4: acc[4], result_c5: acc[5],
                      norm_or_trace: nt, quad_form: quad, abs_weight: absw,
                      signed_sum: ssum, divide_by_zero: dz};

  `CZ_ASSERT_IMP(a_ready_idle, clk, rst, out_valid, !in_ready, "ready while result pending")
  `CZ_ASSERT_IMP(a_div_busy, clk, rst, state == ST_DIV_WAIT && !div_done, div_busy,
      "divider idle while waited on")
  `CZ_ASSERT_NEXT(a_done_after_weight, clk, rst, state == ST_WEIGHT && widx == 4'd8,
      out_valid, "result missing after weights")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ninth-root ring accumulator ALU. Items go in
// through a valid/ready sender and a scoreboard process compares every result
// with a local accumulator model, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import cz9_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  cyclotomic_z9_ring_alu_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // Model accumulator, expected results and run statistics.
  coeff_t    acc_model [6];
  out_item_t expected_q [$];
  int        error_count;
  int        items_sent;
  int        results_seen;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        op_hits [16];

  initial begin
    clk = 1'b0;
  end
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fold nine cyclic terms to six coefficients.
  function automatic void fold_terms(input coeff_t t [9], output coeff_t d [6]);
    for (int r = 0; r < 3; r++) begin
      d[r] = t[r] - t[r+6];
      d[r+3] = t[r+3] - t[r+6];
    end
  endfunction

  // Ring product modulo z^6+z^3+1.
  function automatic void ring_product(input coeff_t a [6], input coeff_t b [6],
                                       output coeff_t d [6]);
    coeff_t t [9];
    for (int i = 0; i < 9; i++) t[i] = '0;
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++)
        t[(i+j)%9] = t[(i+j)%9] + a[i] * b[j];
    fold_terms(t, d);
  endfunction

  // Automorphism z -> z^k.
  function automatic void conjugate(input coeff_t a [6], input int k,
                                    output coeff_t d [6]);
    coeff_t t [9];
    for (int i = 0; i < 9; i++) t[i] = '0;
    for (int i = 0; i < 6; i++) t[(k*i)%9] = t[(k*i)%9] + a[i];
    fold_terms(t, d);
  endfunction

  // Apply one item to the model accumulator and build the expected result.
  function automatic out_item_t apply_item(input in_item_t it);
    out_item_t r;
    coeff_t opnd [6];
    coeff_t tmp [6];
    coeff_t img [6];
    coeff_t nt;
    coeff_t quad;
    coeff_t absw;
    coeff_t ssum;
    coeff_t s;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    int exps [6];
    exps = '{1, 2, 4, 5, 7, 8};
    opnd = '{it.operand_c0, it.operand_c1, it.operand_c2, it.operand_c3,
             it.operand_c4, it.operand_c5};
    s = it.scalar_value;
    nt = '0;
    r = '0;
    case (it.opcode)
      OP_LOAD: acc_model = opnd;
      OP_ADD: for (int i = 0; i < 6; i++) acc_model[i] = acc_model[i] + opnd[i];
      OP_SUB: for (int i = 0; i < 6; i++) acc_model[i] = acc_model[i] - opnd[i];
      OP_MUL: begin
        ring_product(acc_model, opnd, tmp);
        acc_model = tmp;
      end
      OP_SCALE: for (int i = 0; i < 6; i++) acc_model[i] = acc_model[i] * s;
      OP_DIV: begin
        if (s == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          mag_b = s[31] ? -s : s;
          for (int i = 0; i < 6; i++) begin
            mag_a = acc_model[i][31] ? -acc_model[i] : acc_model[i];
            q = mag_a / mag_b;
            acc_model[i] = (acc_model[i][31] != s[31]) ? -q : q;
          end
        end
      end
      OP_GALOIS: begin
        conjugate(acc_model, it.galois_power % 9, tmp);
        acc_model = tmp;
      end
      OP_NORM: begin
        tmp = '{1, 0, 0, 0, 0, 0};
        for (int n = 0; n < 6; n++) begin
          conjugate(acc_model, exps[n], img);
          ring_product(tmp, img, tmp);
        end
        nt = tmp[0];
      end
      OP_TRACE: begin
        for (int n = 0; n < 6; n++) begin
          conjugate(acc_model, exps[n], img);
          nt = nt + img[0];
        end
      end
      default: ;
    endcase
    quad = '0;
    absw = '0;
    ssum = '0;
    for (int i = 0; i < 6; i++) begin
      quad = quad + acc_model[i] * acc_model[i];
      absw = absw + (acc_model[i][31] ? -acc_model[i] : acc_model[i]);
      ssum = ssum + acc_model[i];
    end
    for (int i = 0; i < 3; i++) quad = quad - acc_model[i] * acc_model[i+3];
    r.result_c0 = acc_model[0];
    r.result_c1 = acc_model[1];
    r.result_c2 = acc_model[2];
    r.result_c3 = acc_model[3];
    r.result_c4 = acc_model[4];
    r.result_c5 = acc_model[5];
    r.norm_or_trace = nt;
    r.quad_form = quad;
    r.abs_weight = absw;
    r.signed_sum = ssum;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h (result %0d)", what, got, want,
             results_seen);
    error_count++;
  endtask

  // Send one item: optional idle gap, then hold valid until accepted. Valid
  // stays high after acceptance until the next gap or the next item.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(apply_item(it));
    op_hits[it.opcode]++;
    items_sent++;
  endtask

  // Receiver: random stall, compare each accepted result with the oldest
  // expectation.
  initial begin
    out_item_t want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("unexpected result %0d", results_seen);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.result_c0 !== want.result_c0)
            report_mismatch("c0", out_data.result_c0, want.result_c0);
          if (out_data.result_c1 !== want.result_c1)
            report_mismatch("c1", out_data.result_c1, want.result_c1);
          if (out_data.result_c2 !== want.result_c2)
            report_mismatch("c2", out_data.result_c2, want.result_c2);
          if (out_data.result_c3 !== want.result_c3)
            report_mismatch("c3", out_data.result_c3, want.result_c3);
          if (out_data.result_c4 !== want.result_c4)
            report_mismatch("c4", out_data.result_c4, want.result_c4);
          if (out_data.result_c5 !== want.result_c5)
            report_mismatch("c5", out_data.result_c5, want.result_c5);
          if (out_data.norm_or_trace !== want.norm_or_trace)
            report_mismatch("norm_or_trace", out_data.norm_or_trace,
                            want.norm_or_trace);
          if (out_data.quad_form !== want.quad_form)
            report_mismatch("quad_form", out_data.quad_form, want.quad_form);
          if (out_data.abs_weight !== want.abs_weight)
            report_mismatch("abs_weight", out_data.abs_weight, want.abs_weight);
          if (out_data.signed_sum !== want.signed_sum)
            report_mismatch("signed_sum", out_data.signed_sum, want.signed_sum);
          if (out_data.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", 32'(out_data.divide_by_zero),
                            32'(want.divide_by_zero));
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Random coefficient biased toward edges and small values.
  function automatic coeff_t rand_coeff();
    case ($urandom_range(7, 0))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(20, 0)) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [3:0] op);
    in_item_t it;
    it.opcode = op;
    it.operand_c0 = rand_coeff();
    it.operand_c1 = rand_coeff();
    it.operand_c2 = rand_coeff();
    it.operand_c3 = rand_coeff();
    it.operand_c4 = rand_coeff();
    it.operand_c5 = rand_coeff();
    it.scalar_value = ($urandom_range(5, 0) == 0) ? 32'sd0 : rand_coeff();
    it.galois_power = 4'($urandom_range(15, 0));
    return it;
  endfunction

  // Each operation with extreme operands, zero divisor, MIN / -1, the
  // degenerate Galois exponents, exponents above eight, unused opcodes.
  task automatic test_directed();
    in_item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.operand_c0 = 32'sh80000000; it.operand_c1 = 32'sh7fffffff;
    it.operand_c2 = -1; it.operand_c3 = 1; it.operand_c4 = 5; it.operand_c5 = -7;
    send_item(it);
    it.opcode = OP_TRACE; send_item(it);
    it.opcode = OP_DIV; it.scalar_value = 0; send_item(it);
    it.scalar_value = -1; send_item(it);
    it.scalar_value = 32'sh80000000; send_item(it);
    it.opcode = OP_LOAD; it.operand_c0 = 37; it.operand_c1 = -37; send_item(it);
    it.opcode = OP_DIV; it.scalar_value = 4; send_item(it);
    it.scalar_value = -3; send_item(it);
    it.opcode = OP_SCALE; it.scalar_value = 32'sh7fffffff; send_item(it);
    it.opcode = OP_ADD; send_item(it);
    it.opcode = OP_SUB; it.operand_c3 = 32'sh80000000; send_item(it);
    it.opcode = OP_LOAD; it.operand_c0 = 2; it.operand_c1 = 1; it.operand_c2 = 0;
    it.operand_c3 = 3; it.operand_c4 = -1; it.operand_c5 = 0; send_item(it);
    it.opcode = OP_MUL; send_item(it);
    it.opcode = OP_NORM; send_item(it);
    for (int k = 0; k < 16; k += 3) begin
      it.opcode = OP_GALOIS; it.galois_power = 4'(k); send_item(it);
    end
    it.opcode = 4'd9; send_item(it);
    it.opcode = 4'd15; it.operand_c0 = '1; it.scalar_value = '1;
    it.galois_power = 4'hf; send_item(it);
    it.opcode = OP_LOAD; send_item(it);
    it.opcode = OP_NORM; send_item(it);
  endtask

  // Random items: mostly short load-then-compute chains, some noise.
  task automatic test_random(input int count);
    in_item_t it;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9, 0) == 0) it = make_item(4'($urandom_range(15, 0)));
      else if ($urandom_range(4, 0) == 0) it = make_item(OP_LOAD);
      else it = make_item(4'($urandom_range(8, 1)));
      send_item(it);
    end
  endtask

  // Hold off the sender until the block has delivered every result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    send_idle_pct = 21;
    recv_idle_pct = 63;
    foreach (acc_model[i]) acc_model[i] = '0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(180);
    wait_drained();
    send_idle_pct = 63;
    recv_idle_pct = 21;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(210);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Ran %0d items (%0d norms, %0d divides, %0d unused opcodes),",
             items_sent, op_hits[OP_NORM], op_hits[OP_DIV],
             op_hits[9] + op_hits[10] + op_hits[11] + op_hits[12] + op_hits[13]
             + op_hits[14] + op_hits[15]);
    $display("checked %0d results under three idling patterns.", results_seen);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: fails the run if the roughly 600 items, stalls included, do not finish in time.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

[cyclotomic_z9_ring_alu_unit.f]
+incdir+rtl/core
rtl/core/cz9_pkg.sv
rtl/core/cz9_divider.sv
rtl/core/cyclotomic_z9_ring_alu_unit.sv
dv/tb_top.sv
